[rtl/core/dvrc_pkg.sv]
package dvrc_pkg;

    localparam int MEMO_ENTRIES = 4096;
    localparam int SLOT_W       = $clog2(MEMO_ENTRIES);
    localparam int HASH_SHIFT   = 20;
    localparam int KEY_W        = 32;
    localparam logic [63:0] KEY_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam int N_W    = 22;
    localparam int NEED_W = 33;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        V_ACCEPT       = 3'd0,
        V_TRIVIAL      = 3'd1,
        V_OUT_OF_RANGE = 3'd2,
        V_UNVERIFIABLE = 3'd3,
        V_SCAN         = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        MODE_DIRECT = 2'd0,
        MODE_IDX16  = 2'd1,
        MODE_IDX32  = 2'd2,
        MODE_OPAQUE = 2'd3
    } index_mode_t;

    typedef enum logic {
        KIND_DRAW  = 1'b0,
        KIND_INDEX = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        PRIM_POINTS     = 3'd1,
        PRIM_LINES      = 3'd2,
        PRIM_LINE_STRIP = 3'd3,
        PRIM_TRIANGLES  = 3'd4,
        PRIM_TRI_STRIP  = 3'd5,
        PRIM_FAN        = 3'd6
    } prim_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic        trivial;
        logic [N_W-1:0] elements;
        logic [15:0] stride;
        logic [31:0] vbuf_size;
        index_mode_t index_mode;
        logic [31:0] ibuf_size;
        logic [31:0] start_index;
        logic [31:0] vertex_offset;
        logic [63:0] upload_serial;
        logic [31:0] index_value;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] serial;
        logic [31:0] first;
        logic [N_W-1:0] count;
        logic [31:0] max;
    } memo_entry_t;

    localparam int MEMO_W = $bits(memo_entry_t);

endpackage

[rtl/core/dvrc_ram.sv]
module dvrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dvrc_front.sv]
module dvrc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [2:0]          prim_type,
    input  logic [19:0]         prim_count,
    input  logic [15:0]         stride,
    input  logic [31:0]         vbuf_size,
    input  logic [1:0]          index_mode,
    input  logic [31:0]         ibuf_size,
    input  logic [31:0]         start_index,
    input  logic [31:0]         vertex_offset,
    input  logic [63:0]         upload_serial,
    input  logic [31:0]         index_value,
    output logic                head_valid,
    output dvrc_pkg::item_t     head,
    input  logic                pop
);

    dvrc_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push;
    logic [dvrc_pkg::N_W-1:0] n_ext;
    logic [dvrc_pkg::N_W-1:0] elements;
    dvrc_pkg::item_t item;

    // element count per primitive type
    always_comb
    begin
        n_ext = {2'b00, prim_count};
        case (prim_type)
            dvrc_pkg::PRIM_POINTS:     elements = n_ext;
            dvrc_pkg::PRIM_LINES:      elements = n_ext << 1;
            dvrc_pkg::PRIM_LINE_STRIP: elements = n_ext + dvrc_pkg::N_W'(1);
            dvrc_pkg::PRIM_TRIANGLES:  elements = (n_ext << 1) + n_ext;
            dvrc_pkg::PRIM_TRI_STRIP,
            dvrc_pkg::PRIM_FAN:        elements = n_ext + dvrc_pkg::N_W'(2);
            default:                   elements = '0;
        endcase
        if (prim_count == 20'd0)
        begin
            elements = '0;
        end
    end

    always_comb
    begin
        item.kind          = dvrc_pkg::kind_t'(kind);
        item.elements      = elements;
        item.trivial       = (stride == 16'd0) || (elements == '0);
        item.stride        = stride;
        item.vbuf_size     = vbuf_size;
        item.index_mode    = dvrc_pkg::index_mode_t'(index_mode);
        item.ibuf_size     = ibuf_size;
        item.start_index   = start_index;
        item.vertex_offset = vertex_offset;
        item.upload_serial = upload_serial;
        item.index_value   = index_value;
    end

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[rtl/core/dvrc_back.sv]
module dvrc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  dvrc_pkg::item_t     head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          verdict,
    output logic [32:0]         needed_vertices,
    output logic [31:0]         vertices_held,
    output logic [31:0]         largest_index,
    output logic                from_memo
);

    localparam int SW = dvrc_pkg::SLOT_W;
    localparam int NW = dvrc_pkg::N_W;
    localparam int EW = dvrc_pkg::NEED_W;

    dvrc_pkg::state_t state_reg, state_next;
    dvrc_pkg::item_t  req_reg, req_next;

    logic [dvrc_pkg::DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [dvrc_pkg::KEY_W-1:0] prod_reg, prod_next;
    logic        unverif_reg, unverif_next;
    logic [EW-1:0] need_direct_reg, need_direct_next;
    logic [SW-1:0] clr_cnt_reg, clr_cnt_next;

    logic          scan_active_reg, scan_active_next;
    logic [NW-1:0] scan_remaining_reg, scan_remaining_next;
    logic [31:0]   running_max_reg, running_max_next;
    logic [31:0]   pending_held_reg, pending_held_next;
    logic [31:0]   pending_offset_reg, pending_offset_next;
    logic [SW-1:0] pending_slot_reg, pending_slot_next;
    logic [63:0]   pending_serial_reg, pending_serial_next;
    logic [31:0]   pending_first_reg, pending_first_next;
    logic [NW-1:0] pending_count_reg, pending_count_next;

    logic              out_valid_reg, out_valid_next;
    dvrc_pkg::verdict_t verdict_reg, verdict_next;
    logic [EW-1:0]     need_reg, need_next;
    logic [31:0]       held_reg, held_next;
    logic [31:0]       largest_reg, largest_next;
    logic              memo_reg, memo_next;

    logic          out_free;
    logic          div_done;
    logic [16:0]   rem_try;
    logic [dvrc_pkg::KEY_W-1:0] key_lo;
    logic [SW-1:0] slot;
    logic          hit;
    logic [EW-1:0] need_memo;
    logic [31:0]   scan_peak;
    logic [NW-1:0] scan_rem_dec;
    logic          scan_last;
    logic [EW-1:0] need_scan;
    logic [EW-1:0] last_pos;
    logic [EW+1:0] last_bytes;

    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    dvrc_pkg::memo_entry_t ram_wdata;
    logic          ram_re;
    dvrc_pkg::memo_entry_t ram_rdata;

    dvrc_ram #(
        .WIDTH (dvrc_pkg::MEMO_W),
        .DEPTH (dvrc_pkg::MEMO_ENTRIES)
    ) u_memo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == dvrc_pkg::ST_IDLE) && head_valid && out_free;
    assign div_done = (div_cnt_reg == dvrc_pkg::DCNT_W'(dvrc_pkg::DIV_STEPS - 1));

    assign key_lo = prod_reg ^ dvrc_pkg::KEY_W'(req_reg.elements);
    assign slot   = key_lo[dvrc_pkg::HASH_SHIFT +: SW];
    assign ram_re = (state_reg == dvrc_pkg::ST_DIV) && (div_cnt_reg == '0);

    assign hit = (req_reg.upload_serial != 64'd0) && ram_rdata.valid
                 && (ram_rdata.serial == req_reg.upload_serial)
                 && (ram_rdata.first == req_reg.start_index)
                 && (ram_rdata.count == req_reg.elements);
    assign need_memo = EW'(req_reg.vertex_offset) + EW'(ram_rdata.max) + EW'(1);

    assign scan_peak    = (head.index_value > running_max_reg) ? head.index_value
                                                               : running_max_reg;
    assign scan_rem_dec = (scan_remaining_reg != '0) ? scan_remaining_reg - NW'(1) : '0;
    assign scan_last    = (scan_rem_dec == '0);
    assign need_scan    = EW'(pending_offset_reg) + EW'(scan_peak) + EW'(1);

    assign last_pos   = EW'(head.start_index) + EW'(head.elements);
    assign last_bytes = (head.index_mode == dvrc_pkg::MODE_IDX32) ? {last_pos, 2'b00}
                                                                 : {1'b0, last_pos, 1'b0};

    assign rem_try = {rem_reg[15:0], quo_reg[31]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dvrc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == SW'(dvrc_pkg::MEMO_ENTRIES - 1))
                begin
                    state_next = dvrc_pkg::ST_IDLE;
                end
            end
            dvrc_pkg::ST_IDLE:
            begin
                if (pop && head.kind == dvrc_pkg::KIND_DRAW && !head.trivial)
                begin
                    state_next = dvrc_pkg::ST_DIV;
                end
            end
            dvrc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = dvrc_pkg::ST_DECIDE;
                end
            end
            dvrc_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = dvrc_pkg::ST_IDLE;
                end
            end
            default: state_next = dvrc_pkg::ST_IDLE;
        endcase
    end

    // memo write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pending_slot_reg;
        ram_wdata = '0;
        case (state_reg)
            dvrc_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            dvrc_pkg::ST_IDLE:
            begin
                ram_we = pop && head.kind == dvrc_pkg::KIND_INDEX && scan_active_reg
                         && scan_last && (pending_serial_reg != 64'd0);
                ram_wdata.valid  = 1'b1;
                ram_wdata.serial = pending_serial_reg;
                ram_wdata.first  = pending_first_reg;
                ram_wdata.count  = pending_count_reg;
                ram_wdata.max    = scan_peak;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // datapath and results
    always_comb
    begin
        req_next            = req_reg;
        div_cnt_next        = div_cnt_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        prod_next           = prod_reg;
        unverif_next        = unverif_reg;
        need_direct_next    = need_direct_reg;
        clr_cnt_next        = clr_cnt_reg;
        scan_active_next    = scan_active_reg;
        scan_remaining_next = scan_remaining_reg;
        running_max_next    = running_max_reg;
        pending_held_next   = pending_held_reg;
        pending_offset_next = pending_offset_reg;
        pending_slot_next   = pending_slot_reg;
        pending_serial_next = pending_serial_reg;
        pending_first_next  = pending_first_reg;
        pending_count_next  = pending_count_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        verdict_next        = verdict_reg;
        need_next           = need_reg;
        held_next           = held_reg;
        largest_next        = largest_reg;
        memo_next           = memo_reg;

        case (state_reg)
            dvrc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SW'(1);
            end
            dvrc_pkg::ST_IDLE:
            begin
                if (pop && head.kind == dvrc_pkg::KIND_INDEX)
                begin
                    if (scan_active_reg)
                    begin
                        running_max_next    = scan_peak;
                        scan_remaining_next = scan_rem_dec;
                        if (scan_last)
                        begin
                            scan_active_next = 1'b0;
                            out_valid_next   = 1'b1;
                            verdict_next     = (need_scan <= EW'(pending_held_reg))
                                               ? dvrc_pkg::V_ACCEPT
                                               : dvrc_pkg::V_OUT_OF_RANGE;
                            need_next        = need_scan;
                            held_next        = pending_held_reg;
                            largest_next     = scan_peak;
                            memo_next        = 1'b0;
                        end
                    end
                end
                else if (pop)
                begin
                    scan_active_next = 1'b0;
                    if (head.trivial)
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = dvrc_pkg::V_TRIVIAL;
                        need_next      = '0;
                        held_next      = '0;
                        largest_next   = '0;
                        memo_next      = 1'b0;
                    end
                    else
                    begin
                        req_next         = head;
                        div_cnt_next     = '0;
                        rem_next         = '0;
                        quo_next         = head.vbuf_size;
                        prod_next        = head.upload_serial[dvrc_pkg::KEY_W-1:0]
                                           * dvrc_pkg::KEY_MULT[dvrc_pkg::KEY_W-1:0];
                        unverif_next     = (last_bytes > (EW+2)'(head.ibuf_size));
                        need_direct_next = EW'(head.vertex_offset) + EW'(head.elements);
                    end
                end
            end
            dvrc_pkg::ST_DIV:
            begin
                // one quotient bit per cycle
                div_cnt_next = div_cnt_reg + dvrc_pkg::DCNT_W'(1);
                if (rem_try >= {1'b0, req_reg.stride})
                begin
                    rem_next = rem_try - {1'b0, req_reg.stride};
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
            dvrc_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    held_next      = quo_reg;
                    memo_next      = 1'b0;
                    largest_next   = '0;
                    need_next      = '0;
                    if (req_reg.index_mode == dvrc_pkg::MODE_DIRECT)
                    begin
                        need_next    = need_direct_reg;
                        verdict_next = (need_direct_reg <= EW'(quo_reg))
                                       ? dvrc_pkg::V_ACCEPT : dvrc_pkg::V_OUT_OF_RANGE;
                    end
                    else if (req_reg.index_mode == dvrc_pkg::MODE_OPAQUE || unverif_reg)
                    begin
                        verdict_next = dvrc_pkg::V_UNVERIFIABLE;
                    end
                    else if (hit)
                    begin
                        need_next    = need_memo;
                        largest_next = ram_rdata.max;
                        memo_next    = 1'b1;
                        verdict_next = (need_memo <= EW'(quo_reg))
                                       ? dvrc_pkg::V_ACCEPT : dvrc_pkg::V_OUT_OF_RANGE;
                    end
                    else
                    begin
                        verdict_next        = dvrc_pkg::V_SCAN;
                        scan_active_next    = 1'b1;
                        scan_remaining_next = req_reg.elements;
                        running_max_next    = '0;
                        pending_held_next   = quo_reg;
                        pending_offset_next = req_reg.vertex_offset;
                        pending_slot_next   = slot;
                        pending_serial_next = req_reg.upload_serial;
                        pending_first_next  = req_reg.start_index;
                        pending_count_next  = req_reg.elements;
                    end
                end
            end
            default: out_valid_next = out_valid_reg && !out_ready;
        endcase
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        prod_reg        <= prod_next;
        unverif_reg     <= unverif_next;
        need_direct_reg <= need_direct_next;
        verdict_reg     <= verdict_next;
        need_reg        <= need_next;
        held_reg        <= held_next;
        largest_reg     <= largest_next;
        memo_reg        <= memo_next;
        div_cnt_reg     <= div_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= dvrc_pkg::ST_CLEAR;
            clr_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
            scan_active_reg    <= 1'b0;
            scan_remaining_reg <= '0;
            running_max_reg    <= '0;
            pending_held_reg   <= '0;
            pending_offset_reg <= '0;
            pending_slot_reg   <= '0;
            pending_serial_reg <= '0;
            pending_first_reg  <= '0;
            pending_count_reg  <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            clr_cnt_reg        <= clr_cnt_next;
            out_valid_reg      <= out_valid_next;
            scan_active_reg    <= scan_active_next;
            scan_remaining_reg <= scan_remaining_next;
            running_max_reg    <= running_max_next;
            pending_held_reg   <= pending_held_next;
            pending_offset_reg <= pending_offset_next;
            pending_slot_reg   <= pending_slot_next;
            pending_serial_reg <= pending_serial_next;
            pending_first_reg  <= pending_first_next;
            pending_count_reg  <= pending_count_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign needed_vertices = need_reg;
    assign vertices_held   = held_reg;
    assign largest_index   = largest_reg;
    assign from_memo       = memo_reg;

endmodule

[rtl/core/draw_vertex_range_checker_top.sv]
// Checks draws against the bound vertex buffer. Requests enter a two-entry queue,
// so the input is taken while a verdict waits on the output. Once at the head of
// the queue, a trivial draw (zero stride or no elements) is answered from the idle
// state; any other draw runs the bit-serial vbuf_size / stride divider (32 steps)
// and is then decided, the divider also hiding the memo read. Each streamed index
// of a scan is popped from the idle state while the output is free. After reset,
// a clearing pass writes all 4096 memo entries to reset their valid bits; requests
// queue but are not processed until it ends.
module draw_vertex_range_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [2:0]  prim_type,
    input  logic [19:0] prim_count,
    input  logic [15:0] stride,
    input  logic [31:0] vbuf_size,
    input  logic [1:0]  index_mode,
    input  logic [31:0] ibuf_size,
    input  logic [31:0] start_index,
    input  logic [31:0] vertex_offset,
    input  logic [63:0] upload_serial,
    input  logic [31:0] index_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [32:0] needed_vertices,
    output logic [31:0] vertices_held,
    output logic [31:0] largest_index,
    output logic        from_memo
);

    logic            head_valid;
    dvrc_pkg::item_t head;
    logic            pop;

    dvrc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .prim_type       (prim_type),
        .prim_count      (prim_count),
        .stride          (stride),
        .vbuf_size       (vbuf_size),
        .index_mode      (index_mode),
        .ibuf_size       (ibuf_size),
        .start_index     (start_index),
        .vertex_offset   (vertex_offset),
        .upload_serial   (upload_serial),
        .index_value     (index_value),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop)
    );

    dvrc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .verdict         (verdict),
        .needed_vertices (needed_vertices),
        .vertices_held   (vertices_held),
        .largest_index   (largest_index),
        .from_memo       (from_memo)
    );

    a_memo_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && from_memo |->
            verdict == dvrc_pkg::V_ACCEPT || verdict == dvrc_pkg::V_OUT_OF_RANGE)
        else $error("memo hit with wrong verdict");

    a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == dvrc_pkg::V_TRIVIAL |->
            needed_vertices == '0 && vertices_held == '0 && largest_index == '0)
        else $error("trivial verdict with nonzero fields");

    a_scan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == dvrc_pkg::V_SCAN |->
            needed_vertices == '0 && largest_index == '0 && !from_memo)
        else $error("scan verdict with nonzero fields");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

[tb/dvrc_checker.sv]
`timescale 1ns / 1ps

module dvrc_checker
    import dvrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [2:0]  prim_type,
    input  logic [19:0] prim_count,
    input  logic [15:0] stride,
    input  logic [31:0] vbuf_size,
    input  logic [1:0]  index_mode,
    input  logic [31:0] ibuf_size,
    input  logic [31:0] start_index,
    input  logic [31:0] vertex_offset,
    input  logic [63:0] upload_serial,
    input  logic [31:0] index_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  verdict,
    input  logic [32:0] needed_vertices,
    input  logic [31:0] vertices_held,
    input  logic [31:0] largest_index,
    input  logic        from_memo,
    output int          fail_count,
    output int          pending_verdicts
);

    typedef struct packed {
        verdict_t    verdict;
        logic [32:0] needed;
        logic [31:0] held;
        logic [31:0] largest;
        logic        memo;
    } check_result_t;

    check_result_t verdict_q[$];

    logic        memo_ok [MEMO_ENTRIES];
    logic [63:0] memo_ser [MEMO_ENTRIES];
    logic [31:0] memo_fst [MEMO_ENTRIES];
    logic [31:0] memo_cnt [MEMO_ENTRIES];
    logic [31:0] memo_top [MEMO_ENTRIES];

    logic        scanning;
    logic [31:0] scan_left, scan_top, scan_held, scan_base, scan_fst, scan_cnt;
    logic [63:0] scan_ser;
    int          scan_slot;

    assign pending_verdicts = verdict_q.size();

    function automatic logic [31:0] element_count(logic [2:0] pt, logic [19:0] pc);
        logic [31:0] n;
        n = {12'd0, pc};
        if (n == 0) return 0;
        case (pt)
            PRIM_POINTS:     return n;
            PRIM_LINES:      return 2 * n;
            PRIM_LINE_STRIP: return n + 1;
            PRIM_TRIANGLES:  return 3 * n;
            PRIM_TRI_STRIP, PRIM_FAN: return n + 2;
            default:         return 0;
        endcase
    endfunction

    function automatic int memo_slot(logic [63:0] ser, logic [31:0] fst, logic [31:0] cnt);
        logic [63:0] key;
        key = (ser * KEY_MULT) ^ {fst, 32'd0} ^ {32'd0, cnt};
        return int'((key >> HASH_SHIFT) % MEMO_ENTRIES);
    endfunction

    task automatic push(verdict_t v, logic [32:0] nd, logic [31:0] hd,
                        logic [31:0] lg, logic mm);
        check_result_t r;
        r.verdict = v; r.needed = nd; r.held = hd; r.largest = lg; r.memo = mm;
        verdict_q.push_back(r);
    endtask

    task automatic predict_request();
        logic [31:0] n, have;
        logic [35:0] last_byte;
        logic [32:0] need;
        int          s;
        n = element_count(prim_type, prim_count);
        scanning = 1'b0;
        if (stride == 0 || n == 0) begin
            push(V_TRIVIAL, 0, 0, 0, 0);
            return;
        end
        have = vbuf_size / {16'd0, stride};
        if (index_mode == MODE_DIRECT) begin
            need = {1'b0, vertex_offset} + {1'b0, n};
            push(need <= {1'b0, have} ? V_ACCEPT : V_OUT_OF_RANGE, need, have, 0, 0);
            return;
        end
        last_byte = ({4'd0, start_index} + {4'd0, n}) * (index_mode == MODE_IDX32 ? 4 : 2);
        if (index_mode == MODE_OPAQUE || last_byte > {4'd0, ibuf_size}) begin
            push(V_UNVERIFIABLE, 0, have, 0, 0);
            return;
        end
        s = memo_slot(upload_serial, start_index, n);
        if (upload_serial != 0 && memo_ok[s] && memo_ser[s] == upload_serial &&
            memo_fst[s] == start_index && memo_cnt[s] == n)
        begin
            need = {1'b0, vertex_offset} + {1'b0, memo_top[s]} + 33'd1;
            push(need <= {1'b0, have} ? V_ACCEPT : V_OUT_OF_RANGE, need, have,
                 memo_top[s], 1);
            return;
        end
        scanning = 1'b1; scan_left = n; scan_top = 0; scan_held = have;
        scan_base = vertex_offset; scan_slot = s; scan_ser = upload_serial;
        scan_fst = start_index; scan_cnt = n;
        push(V_SCAN, 0, have, 0, 0);
    endtask

    task automatic predict_index();
        logic [32:0] need;
        if (!scanning) return;
        if (index_value > scan_top) scan_top = index_value;
        if (scan_left > 0) scan_left = scan_left - 1;
        if (scan_left != 0) return;
        scanning = 1'b0;
        if (scan_ser != 0) begin
            memo_ok[scan_slot] = 1'b1; memo_ser[scan_slot] = scan_ser;
            memo_fst[scan_slot] = scan_fst; memo_cnt[scan_slot] = scan_cnt;
            memo_top[scan_slot] = scan_top;
        end
        need = {1'b0, scan_base} + {1'b0, scan_top} + 33'd1;
        push(need <= {1'b0, scan_held} ? V_ACCEPT : V_OUT_OF_RANGE, need, scan_held,
             scan_top, 0);
    endtask

    always @(posedge clk or negedge rst_n) begin
        check_result_t e;
        if (!rst_n) begin
            fail_count = 0;
            scanning = 1'b0;
            scan_left = 0;
            verdict_q.delete();
            for (int i = 0; i < MEMO_ENTRIES; i++) memo_ok[i] = 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected verdict %0d", verdict);
                    fail_count++;
                end
                else begin
                    e = verdict_q.pop_front();
                    if (verdict !== e.verdict) begin
                        $error("verdict exp %0d got %0d", e.verdict, verdict);
                        fail_count++;
                    end
                    if (needed_vertices !== e.needed) begin
                        $error("needed_vertices exp %0d got %0d", e.needed, needed_vertices);
                        fail_count++;
                    end
                    if (vertices_held !== e.held) begin
                        $error("vertices_held exp %0d got %0d", e.held, vertices_held);
                        fail_count++;
                    end
                    if (largest_index !== e.largest) begin
                        $error("largest_index exp %0d got %0d", e.largest, largest_index);
                        fail_count++;
                    end
                    if (from_memo !== e.memo) begin
                        $error("from_memo exp %0d got %0d", e.memo, from_memo);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (kind == KIND_INDEX) predict_index();
                else predict_request();
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import dvrc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [2:0]  prim_type;
    logic [19:0] prim_count;
    logic [15:0] stride;
    logic [31:0] vbuf_size;
    logic [1:0]  index_mode;
    logic [31:0] ibuf_size;
    logic [31:0] start_index;
    logic [31:0] vertex_offset;
    logic [63:0] upload_serial;
    logic [31:0] index_value;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  verdict;
    logic [32:0] needed_vertices;
    logic [31:0] vertices_held;
    logic [31:0] largest_index;
    logic        from_memo;
    int          fail_count;
    int          pending_verdicts;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    int          random_requests;

    logic [63:0] recent_serial [4];
    logic [31:0] recent_first [4];
    logic [19:0] recent_count [4];
    logic [2:0]  recent_type [4];

    draw_vertex_range_checker_top dut (.*);

    dvrc_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_item();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_request(logic [2:0] pt, logic [19:0] pc, logic [15:0] sd,
                                logic [31:0] vb, index_mode_t im, logic [31:0] ib,
                                logic [31:0] fi, logic [31:0] vo, logic [63:0] us);
        kind <= KIND_DRAW; prim_type <= pt; prim_count <= pc; stride <= sd;
        vbuf_size <= vb; index_mode <= im; ibuf_size <= ib; start_index <= fi;
        vertex_offset <= vo; upload_serial <= us; index_value <= $urandom;
        send_item();
    endtask

    task automatic send_index(logic [31:0] v);
        kind <= KIND_INDEX; index_value <= v;
        prim_type <= $urandom; prim_count <= $urandom; stride <= $urandom;
        vbuf_size <= $urandom; index_mode <= $urandom; ibuf_size <= $urandom;
        start_index <= $urandom; vertex_offset <= $urandom;
        upload_serial <= {$urandom, $urandom};
        send_item();
    endtask

    task automatic send_indices(int n, logic [31:0] lim);
        for (int i = 0; i < n; i++)
            send_index($urandom_range(3) == 0 ? $urandom : $urandom_range(lim));
    endtask

    // mostly well-formed indexed draw with a short scan, often a repeat to hit the memo
    task automatic indexed_draw();
        int          r;
        logic [2:0]  pt;
        logic [19:0] pc;
        logic [31:0] fi;
        logic [63:0] us;
        index_mode_t im;
        int          n;
        logic [31:0] vbytes;
        r = $urandom_range(3);
        if ($urandom_range(2) == 0) begin
            pt = recent_type[r]; pc = recent_count[r];
            fi = recent_first[r]; us = recent_serial[r];
        end
        else begin
            pt = $urandom_range(1, 6); pc = $urandom_range(1, 4);
            fi = $urandom_range(3) == 0 ? $urandom : $urandom_range(1000);
            us = $urandom_range(5) == 0 ? 64'd0 : {$urandom, $urandom};
            recent_type[r] = pt; recent_count[r] = pc;
            recent_first[r] = fi; recent_serial[r] = us;
        end
        im = $urandom_range(1) ? MODE_IDX32 : MODE_IDX16;
        vbytes = $urandom_range(1) ? $urandom_range(200000) : $urandom;
        send_request(pt, pc, $urandom_range(1, 64), vbytes, im, 32'hFFFF_FFFF, fi,
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(500), us);
        n = pt == PRIM_POINTS ? pc : pt == PRIM_LINES ? 2 * pc : pt == PRIM_LINE_STRIP ?
            pc + 1 : pt == PRIM_TRIANGLES ? 3 * pc : pc + 2;
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        send_indices(n, 3000);
    endtask

    task automatic random_request();
        send_request($urandom, $urandom_range(3) == 0 ? $urandom : $urandom_range(20),
                     $urandom_range(3) == 0 ? 16'd0 + $urandom : $urandom_range(64),
                     $urandom, index_mode_t'($urandom_range(3)),
                     $urandom_range(1) ? $urandom : $urandom_range(200),
                     $urandom_range(1) ? $urandom : $urandom_range(50), $urandom,
                     {$urandom, $urandom});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_verdicts != 0) @(negedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_DRAW;
        prim_type = '0; prim_count = '0; stride = '0; vbuf_size = '0;
        index_mode = '0; ibuf_size = '0; start_index = '0; vertex_offset = '0;
        upload_serial = '0; index_value = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        for (int i = 0; i < 4; i++)
        begin
            recent_serial[i] = i + 1; recent_first[i] = i;
            recent_count[i] = 1; recent_type[i] = PRIM_POINTS;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every type and mode, trivial, unverifiable, scans
        send_index(32'h1234);
        send_request(PRIM_POINTS, 20'd5, 16'd0, 32'd100, MODE_DIRECT, 0, 0, 0, 0);
        send_request(3'd0, 20'd5, 16'd4, 32'd100, MODE_DIRECT, 0, 0, 0, 0);
        send_request(3'd7, 20'd5, 16'd4, 32'd100, MODE_DIRECT, 0, 0, 0, 0);
        send_request(PRIM_TRIANGLES, 20'd0, 16'd4, 32'd100, MODE_DIRECT, 0, 0, 0, 0);
        send_request(PRIM_POINTS, 20'd25, 16'd4, 32'd100, MODE_DIRECT, 0, 0, 0, 0);
        send_request(PRIM_LINES, 20'hFFFFF, 16'hFFFF, 32'hFFFF_FFFF, MODE_DIRECT,
                     '1, '1, 32'hFFFF_FFFF, '1);
        send_request(PRIM_LINE_STRIP, 20'd3, 16'd1, 32'd4, MODE_DIRECT, 0, 0, 0, 0);
        send_request(PRIM_TRI_STRIP, 20'd3, 16'd1, 32'd4, MODE_DIRECT, 0, 0, 0, 0);
        send_request(PRIM_FAN, 20'hFFFFF, 16'd1, '1, MODE_OPAQUE, '1, 0, 0, 1);
        send_request(PRIM_TRIANGLES, 20'd2, 16'd8, 32'd800, MODE_IDX16, 32'd11, 0, 0, 7);
        send_request(PRIM_TRIANGLES, 20'd2, 16'd8, 32'd800, MODE_IDX32, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 0, 7);
        send_request(PRIM_TRIANGLES, 20'd2, 16'd8, 32'd800, MODE_IDX16, 32'd12, 0, 5, 7);
        send_indices(6, 100);
        send_request(PRIM_TRIANGLES, 20'd2, 16'd8, 32'd800, MODE_IDX16, 32'd12, 0, 5, 7);
        send_request(PRIM_POINTS, 20'd2, 16'd8, 32'd800, MODE_IDX32, 32'd8, 0, '1, 0);
        send_index(32'hFFFF_FFFF);
        send_index(32'd0);
        send_request(PRIM_LINES, 20'd2, 16'd8, 32'd800, MODE_IDX32, 32'd100, 1, 0, '1);
        send_index(32'd3);
        send_request(PRIM_POINTS, 20'd1, 16'd8, 32'd800, MODE_IDX32, 32'd100, 1, 0, '1);
        send_index(32'd98);
        drain();

        // phases of send idling and receive stalls, the last one with light idling on both sides, before a pause
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = ph == 1 || ph == 3 ? 72 : 0;
            recv_stall_pct = ph == 2 || ph == 3 ? 72 : 0;
            if (ph == 3) begin send_idle_pct = 16; recv_stall_pct = 16; end
            random_requests = 0;
            while (random_requests < 20) begin
                if ($urandom_range(4) == 0) begin
                    random_request();
                    if ($urandom_range(3) == 0) send_index($urandom);
                end
                else indexed_draw();
                random_requests++;
            end
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;

        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending_verdicts == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dvrc_pkg.sv
rtl/core/dvrc_ram.sv
rtl/core/dvrc_front.sv
rtl/core/dvrc_back.sv
rtl/core/draw_vertex_range_checker_top.sv
tb/dvrc_checker.sv
tb/tb.sv
